// ===== src/srlp_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the sensor record line parser.
// No dependencies; imported by every module of the block.
package srlp_pkg;

    localparam int CFG_ADDR_W = 1;
    localparam int CFG_DATA_W = 12;
    localparam int TDATA_W    = 48;

    localparam logic [CFG_ADDR_W-1:0] REG_YEAR_MIN = 1'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_YEAR_MAX = 1'd1;

    localparam logic [11:0] YEAR_MIN_RST = 12'd1900;
    localparam logic [11:0] YEAR_MAX_RST = 12'd3000;

    localparam logic [14:0] NUM_SAT      = 15'd32767;
    localparam logic [14:0] MONTH_LIMIT  = 15'd13;
    localparam logic [14:0] DAY_LIMIT    = 15'd32;
    localparam logic [14:0] HOUR_LIMIT   = 15'd25;
    localparam logic [14:0] MINUTE_LIMIT = 15'd61;
    localparam logic [14:0] TEMP_LIMIT   = 15'd100;

    localparam logic [3:0] FIELD_YEAR   = 4'd0;
    localparam logic [3:0] FIELD_MONTH  = 4'd1;
    localparam logic [3:0] FIELD_DAY    = 4'd2;
    localparam logic [3:0] FIELD_HOUR   = 4'd3;
    localparam logic [3:0] FIELD_MINUTE = 4'd4;
    localparam logic [3:0] FIELD_TEMP   = 4'd5;
    localparam logic [3:0] FIELD_MAX    = 4'd15;
    localparam logic [3:0] FIELDS_FULL  = 4'd6;
    localparam logic [3:0] FIELDS_ONE   = 4'd1;

    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_SPACE = 8'h20;

    typedef enum logic [3:0] {
        ST_OK        = 4'd0,
        ST_YEAR      = 4'd1,
        ST_MONTH     = 4'd2,
        ST_DAY       = 4'd3,
        ST_HOUR      = 4'd4,
        ST_MINUTE    = 4'd5,
        ST_TEMP      = 4'd6,
        ST_EXTRA     = 4'd7,
        ST_BAD_CHAR  = 4'd8,
        ST_EOF_OK    = 4'd9,
        ST_EOF_BAD   = 4'd10
    } status_t;

    typedef struct packed {
        logic [11:0]       year;
        logic [3:0]        month;
        logic [4:0]        day;
        logic [4:0]        hour;
        logic [5:0]        minute;
        logic signed [7:0] temp;
        logic [3:0]        field_count;
        status_t           status;
        logic              at_eof;
    } result_t;

endpackage

// ===== src/srlp_parse.sv =====
`timescale 1ns / 1ps
// Per-character parser: line state, stored record and year limits.
// Depends on srlp_pkg. Produces at most one result per accepted character.
module srlp_parse (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_we,
    input  logic [srlp_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  logic [srlp_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    input  logic                              in_accept,
    input  logic [7:0]                        char_in,
    input  logic                              end_of_file,
    output logic                              res_valid,
    output srlp_pkg::result_t                 res
);
    import srlp_pkg::*;

    logic [11:0]       year_min_reg, year_max_reg;
    logic [14:0]       acc_reg, acc_next;
    logic              neg_reg, neg_next;
    logic [3:0]        fi_reg, fi_next;
    status_t           err_reg, err_next;
    logic [11:0]       year_reg, year_next;
    logic [3:0]        month_reg, month_next;
    logic [4:0]        day_reg, day_next;
    logic [4:0]        hour_reg, hour_next;
    logic [5:0]        minute_reg, minute_next;
    logic signed [7:0] temp_reg, temp_next;

    // values after closing the open field
    logic [11:0]       cl_year;
    logic [3:0]        cl_month;
    logic [4:0]        cl_day;
    logic [4:0]        cl_hour;
    logic [5:0]        cl_minute;
    logic signed [7:0] cl_temp;
    logic [3:0]        cl_fi;
    status_t           cl_err;

    logic [18:0]       prod;
    logic              is_digit;
    status_t           res_status;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            year_min_reg <= YEAR_MIN_RST;
            year_max_reg <= YEAR_MAX_RST;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                REG_YEAR_MIN: year_min_reg <= cfg_wdata;
                REG_YEAR_MAX: year_max_reg <= cfg_wdata;
                default:      ;
            endcase
        end
    end

    always_comb begin
        cl_year   = year_reg;
        cl_month  = month_reg;
        cl_day    = day_reg;
        cl_hour   = hour_reg;
        cl_minute = minute_reg;
        cl_temp   = temp_reg;
        cl_err    = err_reg;
        unique case (fi_reg)
            FIELD_YEAR: begin
                if (acc_reg >= {3'b0, year_min_reg} && acc_reg <= {3'b0, year_max_reg})
                    cl_year = acc_reg[11:0];
                else
                    cl_err = ST_YEAR;
            end
            FIELD_MONTH: begin
                if (acc_reg != '0 && acc_reg < MONTH_LIMIT) cl_month = acc_reg[3:0];
                else cl_err = ST_MONTH;
            end
            FIELD_DAY: begin
                if (acc_reg != '0 && acc_reg < DAY_LIMIT) cl_day = acc_reg[4:0];
                else cl_err = ST_DAY;
            end
            FIELD_HOUR: begin
                if (acc_reg < HOUR_LIMIT) cl_hour = acc_reg[4:0];
                else cl_err = ST_HOUR;
            end
            FIELD_MINUTE: begin
                if (acc_reg < MINUTE_LIMIT) cl_minute = acc_reg[5:0];
                else cl_err = ST_MINUTE;
            end
            FIELD_TEMP: begin
                if (acc_reg < TEMP_LIMIT)
                    cl_temp = neg_reg ? (8'sd0 - $signed(acc_reg[7:0]))
                                      : $signed(acc_reg[7:0]);
                else
                    cl_err = ST_TEMP;
            end
            default: cl_err = ST_EXTRA;
        endcase
        cl_fi = (fi_reg != FIELD_MAX) ? fi_reg + 4'd1 : fi_reg;
    end

    always_comb begin
        is_digit    = (char_in >= CH_0) && (char_in <= CH_9);
        prod        = {acc_reg, 3'b000} + {3'b000, acc_reg, 1'b0}
                      + {15'd0, char_in[3:0]};
        acc_next    = acc_reg;
        neg_next    = neg_reg;
        fi_next     = fi_reg;
        err_next    = err_reg;
        year_next   = year_reg;
        month_next  = month_reg;
        day_next    = day_reg;
        hour_next   = hour_reg;
        minute_next = minute_reg;
        temp_next   = temp_reg;
        res_valid   = 1'b0;
        res_status  = err_reg;
        if (in_accept) begin
            priority if (end_of_file || char_in == CH_SEMI || char_in == CH_LF) begin
                year_next   = cl_year;
                month_next  = cl_month;
                day_next    = cl_day;
                hour_next   = cl_hour;
                minute_next = cl_minute;
                temp_next   = cl_temp;
                fi_next     = cl_fi;
                err_next    = cl_err;
                acc_next    = '0;
                if (end_of_file) begin
                    res_status = (cl_fi == FIELDS_FULL || cl_fi == FIELDS_ONE)
                                 ? ST_EOF_OK : ST_EOF_BAD;
                    res_valid  = 1'b1;
                end else if (char_in == CH_LF) begin
                    res_status = cl_err;
                    res_valid  = 1'b1;
                end
            end else if (is_digit) begin
                acc_next = (prod > {4'd0, NUM_SAT}) ? NUM_SAT : prod[14:0];
            end else if (char_in == CH_MINUS) begin
                if (acc_reg == '0) neg_next = 1'b1;
                else err_next = ST_YEAR;
            end else if (char_in == CH_SPACE) begin
            end else begin
                err_next = ST_BAD_CHAR;
            end
            if (res_valid) begin
                acc_next = '0;
                neg_next = 1'b0;
                fi_next  = '0;
                err_next = ST_OK;
            end
        end
        res.year        = cl_year;
        res.month       = cl_month;
        res.day         = cl_day;
        res.hour        = cl_hour;
        res.minute      = cl_minute;
        res.temp        = cl_temp;
        res.field_count = cl_fi;
        res.status      = res_status;
        res.at_eof      = end_of_file;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg    <= '0;
            neg_reg    <= 1'b0;
            fi_reg     <= '0;
            err_reg    <= ST_OK;
            year_reg   <= '0;
            month_reg  <= '0;
            day_reg    <= '0;
            hour_reg   <= '0;
            minute_reg <= '0;
            temp_reg   <= '0;
        end else begin
            acc_reg    <= acc_next;
            neg_reg    <= neg_next;
            fi_reg     <= fi_next;
            err_reg    <= err_next;
            year_reg   <= year_next;
            month_reg  <= month_next;
            day_reg    <= day_next;
            hour_reg   <= hour_next;
            minute_reg <= minute_next;
            temp_reg   <= temp_next;
        end
    end

endmodule

// ===== src/sensor_record_line_parser.sv =====
`timescale 1ns / 1ps
// Sensor record line parser, top level: stream ports, output register and skid stage.
// Depends on srlp_pkg and srlp_parse.
//
// Usage:
//   The slave channel takes one log character per transaction in s_tdata[7:0];
//   s_tuser high marks end of file (the character is then ignored).
//   Each newline or end of file yields one record transaction on the master
//   channel; other characters only update the line state and stored record.
//   Throughput: one character per cycle, sustained, while s_tready is high;
//   the per-character update (accumulate, range check, record store) is
//   combinational logic between the parser state registers.
//   Output: a record is registered in the output register (first in the skid stage
//   while the output is stalled) and shown on m_tvalid from there.
//   Stall: the output register plus a one-entry skid stage let s_tready stay
//   high while one record waits; s_tready drops only when both are full.
//   Reset (aresetn low, synchronous): line state and stored record clear to
//   zero, year limits return to 1900 and 3000, both channels go empty. Year limits
//   are written through cfg_we/cfg_addr/cfg_wdata while idle (user rule, unchecked).
module sensor_record_line_parser (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   cfg_we,
    input  logic [srlp_pkg::CFG_ADDR_W-1:0]        cfg_addr,
    input  logic [srlp_pkg::CFG_DATA_W-1:0]        cfg_wdata,
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    input  logic [7:0]                             s_tdata,   // char_in
    input  logic                                   s_tuser,   // end_of_file
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    // year, month, day, hour, minute, temperature, field_count, status
    output logic [srlp_pkg::TDATA_W-1:0]           m_tdata,
    output logic                                   m_tuser    // at_eof
);
    import srlp_pkg::*;

    logic    in_accept;
    logic    res_valid;
    result_t res;
    logic    out_valid_reg, out_valid_next;
    result_t out_data_reg, out_data_next;
    logic    skid_valid_reg, skid_valid_next;
    result_t skid_data_reg, skid_data_next;

    assign s_tready  = !skid_valid_reg;
    assign in_accept = s_tvalid && s_tready;

    srlp_parse u_parse (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_we      (cfg_we),
        .cfg_addr    (cfg_addr),
        .cfg_wdata   (cfg_wdata),
        .in_accept   (in_accept),
        .char_in     (s_tdata),
        .end_of_file (s_tuser),
        .res_valid   (res_valid),
        .res         (res)
    );

    always_comb begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (!out_valid_reg || m_tready) begin
            if (skid_valid_reg) begin
                out_valid_next  = 1'b1;
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end else begin
                out_valid_next = res_valid;
                out_data_next  = res;
            end
        end else if (res_valid) begin
            skid_valid_next = 1'b1;
            skid_data_next  = res;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_data_reg.status, out_data_reg.field_count, out_data_reg.temp,
                       out_data_reg.minute, out_data_reg.hour, out_data_reg.day,
                       out_data_reg.month, out_data_reg.year};
    assign m_tuser  = out_data_reg.at_eof;

endmodule

// ===== src/srlp_checker.sv =====
`timescale 1ns / 1ps
// Port-level checks for the sensor record line parser, bound to the top level.
// Depends on srlp_pkg for status codes.
module srlp_checker (
    input logic                         aclk,
    input logic                         aresetn,
    input logic                         s_tready,
    input logic                         m_tvalid,
    input logic                         m_tready,
    input logic [srlp_pkg::TDATA_W-1:0] m_tdata,
    input logic                         m_tuser
);
    import srlp_pkg::*;

    logic [3:0] m_status;
    assign m_status = m_tdata[47:44];

    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("master channel valid right after reset");

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled record changed");

    a_full_backpressure: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid)
        else $error("input stalled with empty output");

    a_eof_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_status == ST_EOF_OK || m_status == ST_EOF_BAD)
        else $error("end-of-file record without end-of-file status");

    a_line_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> m_status != ST_EOF_OK && m_status != ST_EOF_BAD)
        else $error("newline record with end-of-file status");

endmodule

bind sensor_record_line_parser srlp_checker u_srlp_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

// ===== test/srlp_record_checker.sv =====
`timescale 1ns / 1ps
// Record checker for the sensor record line parser: watches the config port and both
// stream channels, predicts each record from the characters and compares it.
// Depends on srlp_pkg.
module srlp_record_checker (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_we,
    input  logic [srlp_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [srlp_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  logic                            s_tvalid,
    input  logic                            s_tready,
    input  logic [7:0]                      s_tdata,
    input  logic                            s_tuser,
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic [srlp_pkg::TDATA_W-1:0]    m_tdata,
    input  logic                            m_tuser,
    output int                              mismatches,
    output int                              pending,
    output int                              checked
);
    import srlp_pkg::*;

    logic [11:0] year_lo = YEAR_MIN_RST;
    logic [11:0] year_hi = YEAR_MAX_RST;
    logic [14:0] accum = '0;
    logic        neg_seen = 1'b0;
    logic [3:0]  field_idx = '0;
    status_t     line_status = ST_OK;
    result_t     rec = '0;
    result_t     expected_records[$];
    int          fail_cnt = 0;
    int          n_checked = 0;

    function automatic string record_text(input result_t r);
        return $sformatf("y=%0d mo=%0d d=%0d h=%0d mi=%0d t=%0d n=%0d st=%0d eof=%0b",
                         r.year, r.month, r.day, r.hour, r.minute, r.temp,
                         r.field_count, r.status, r.at_eof);
    endfunction

    task automatic close_open_field();
        case (field_idx)
            FIELD_YEAR: begin
                if (accum >= {3'd0, year_lo} && accum <= {3'd0, year_hi}) rec.year = accum[11:0];
                else line_status = ST_YEAR;
            end
            FIELD_MONTH: begin
                if (accum != '0 && accum < MONTH_LIMIT) rec.month = accum[3:0];
                else line_status = ST_MONTH;
            end
            FIELD_DAY: begin
                if (accum != '0 && accum < DAY_LIMIT) rec.day = accum[4:0];
                else line_status = ST_DAY;
            end
            FIELD_HOUR: begin
                if (accum < HOUR_LIMIT) rec.hour = accum[4:0];
                else line_status = ST_HOUR;
            end
            FIELD_MINUTE: begin
                if (accum < MINUTE_LIMIT) rec.minute = accum[5:0];
                else line_status = ST_MINUTE;
            end
            FIELD_TEMP: begin
                if (accum < TEMP_LIMIT) rec.temp = neg_seen ? (8'd0 - accum[7:0]) : accum[7:0];
                else line_status = ST_TEMP;
            end
            default: begin
                line_status = ST_EXTRA;
            end
        endcase
        if (field_idx != FIELD_MAX) field_idx++;
        accum = '0;
    endtask

    task automatic parse_char(input logic [7:0] c, input logic eof);
        result_t r;
        logic    emit;
        int      n;
        emit = 1'b0;
        if (eof) begin
            close_open_field();
            line_status = (field_idx == FIELDS_FULL || field_idx == FIELDS_ONE) ?
                          ST_EOF_OK : ST_EOF_BAD;
            emit = 1'b1;
        end else if (c >= CH_0 && c <= CH_9) begin
            n = int'(accum) * 10 + int'(c - CH_0);
            accum = (n > int'(NUM_SAT)) ? NUM_SAT : n[14:0];
        end else if (c == CH_MINUS) begin
            // misplaced minus shares the year code
            if (accum == '0) neg_seen = 1'b1;
            else line_status = ST_YEAR;
        end else if (c == CH_SEMI) begin
            close_open_field();
        end else if (c == CH_LF) begin
            close_open_field();
            emit = 1'b1;
        end else if (c != CH_SPACE) begin
            line_status = ST_BAD_CHAR;
        end
        if (emit) begin
            r = rec;
            r.field_count = field_idx;
            r.status = line_status;
            r.at_eof = eof;
            expected_records.push_back(r);
            accum = '0;
            neg_seen = 1'b0;
            field_idx = '0;
            line_status = ST_OK;
        end
    endtask

    task automatic check_record();
        result_t want;
        result_t got;
        got = '0;
        got.year = m_tdata[11:0];
        got.month = m_tdata[15:12];
        got.day = m_tdata[20:16];
        got.hour = m_tdata[25:21];
        got.minute = m_tdata[31:26];
        got.temp = m_tdata[39:32];
        got.field_count = m_tdata[43:40];
        got.status = status_t'(m_tdata[47:44]);
        got.at_eof = m_tuser;
        if (expected_records.size() == 0) begin
            fail_cnt++;
            if (fail_cnt <= 10) $display("unexpected record: %s", record_text(got));
        end else begin
            want = expected_records.pop_front();
            n_checked++;
            if (got.year !== want.year || got.month !== want.month || got.day !== want.day ||
                got.hour !== want.hour || got.minute !== want.minute ||
                got.temp !== want.temp || got.field_count !== want.field_count ||
                got.status !== want.status || got.at_eof !== want.at_eof) begin
                fail_cnt++;
                if (fail_cnt <= 10) begin
                    $display("record mismatch #%0d", n_checked);
                    $display("  expected %s", record_text(want));
                    $display("  actual   %s", record_text(got));
                end
            end
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            year_lo = YEAR_MIN_RST;
            year_hi = YEAR_MAX_RST;
            accum = '0;
            neg_seen = 1'b0;
            field_idx = '0;
            line_status = ST_OK;
            rec = '0;
            expected_records.delete();
        end else begin
            if (m_tvalid && m_tready) check_record();
            if (cfg_we) begin
                if (cfg_addr == REG_YEAR_MIN) year_lo = cfg_wdata;
                else if (cfg_addr == REG_YEAR_MAX) year_hi = cfg_wdata;
            end
            if (s_tvalid && s_tready) parse_char(s_tdata, s_tuser);
        end
        mismatches <= fail_cnt;
        pending <= expected_records.size();
        checked <= n_checked;
    end

endmodule

// ===== test/tb_sensor_record_line_parser.sv =====
`timescale 1ns / 1ps
// Testbench top for the sensor record line parser: clock, reset, log text stimulus,
// year-limit settings and receiver stalls. Depends on srlp_pkg, srlp_record_checker, RTL.
module tb_sensor_record_line_parser;
    import srlp_pkg::*;

    localparam int          LIMIT_CYCLES = 200000;
    localparam int          HOLD_CYCLES  = 300;
    localparam int          PHASE_CHARS  = 135;
    localparam logic [7:0]  CH_CR        = 8'h0D;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [7:0]            s_tdata = '0;
    logic                  s_tuser = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [TDATA_W-1:0]    m_tdata;
    logic                  m_tuser;

    int mismatches;
    int pending;
    int checked;
    int sent = 0;
    int lines = 0;
    int settings = 1;
    int burst_left = 0;
    int hold_req = 0;
    logic [11:0] cur_lo = YEAR_MIN_RST;
    logic [11:0] cur_hi = YEAR_MAX_RST;

    sensor_record_line_parser u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    srlp_record_checker u_check (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_we     (cfg_we),
        .cfg_addr   (cfg_addr),
        .cfg_wdata  (cfg_wdata),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .mismatches (mismatches),
        .pending    (pending),
        .checked    (checked)
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    initial begin
        repeat (LIMIT_CYCLES) @(posedge aclk);
        $display("timeout after %0d cycles", LIMIT_CYCLES);
        $display("Test completed with failures");
        $finish;
    end

    // receiver: changing stall modes, plus long hold-offs on request
    initial begin
        int mode;
        int mode_left;
        int hold_seen;
        int hold_left;
        mode = 0;
        mode_left = 0;
        hold_seen = 0;
        hold_left = 0;
        forever begin
            @(negedge aclk);
            if (hold_req != hold_seen) begin
                hold_seen = hold_req;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                if (mode_left == 0) begin
                    mode = $urandom_range(0, 3);
                    mode_left = $urandom_range(20, 150);
                end
                mode_left--;
                case (mode)
                    0: m_tready <= 1'b1;
                    1: m_tready <= 1'($urandom_range(0, 1));
                    2: m_tready <= ($urandom_range(0, 3) == 0);
                    default: m_tready <= ($urandom_range(0, 7) != 0);
                endcase
            end
        end
    end

    task automatic send_item(input logic [7:0] c, input logic eof);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 5);
            if (gap > 0) begin
                @(negedge aclk);
                s_tvalid <= 1'b0;
                repeat (gap - 1) @(negedge aclk);
            end
            burst_left = $urandom_range(1, 30);
        end
        burst_left--;
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata <= c;
        s_tuser <= eof;
        do @(posedge aclk); while (!s_tready);
        if (eof || c != CH_SPACE) sent++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) send_item(s[i], 1'b0);
    endtask

    task automatic send_eof();
        send_item(8'($urandom_range(0, 255)), 1'b1);
    endtask

    task automatic send_number(input int v);
        int digits [6];
        int n;
        n = 0;
        do begin
            digits[n] = v % 10;
            v = v / 10;
            n++;
        end while (v > 0 && n < 6);
        for (int i = n - 1; i >= 0; i--) send_item(CH_0 + 8'(digits[i]), 1'b0);
    endtask

    task automatic maybe_space();
        if ($urandom_range(0, 19) == 0) send_item(CH_SPACE, 1'b0);
    endtask

    task automatic end_line(input int eof_pct);
        if ($urandom_range(0, 99) < eof_pct) begin
            send_eof();
        end else begin
            if ($urandom_range(0, 19) == 0) send_item(CH_CR, 1'b0);
            send_item(CH_LF, 1'b0);
        end
    endtask

    task automatic send_record_line();
        int  v [6];
        logic neg;
        if (cur_lo <= cur_hi && $urandom_range(0, 9) != 0) v[0] = $urandom_range(cur_lo, cur_hi);
        else v[0] = $urandom_range(0, 40000);
        v[1] = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 99) : $urandom_range(1, 12);
        v[2] = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 99) : $urandom_range(1, 31);
        v[3] = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 99) : $urandom_range(0, 24);
        v[4] = ($urandom_range(0, 9) == 0) ? $urandom_range(61, 99) : $urandom_range(0, 60);
        v[5] = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 999) : $urandom_range(0, 99);
        neg = 1'($urandom_range(0, 1));
        for (int i = 0; i < 6; i++) begin
            maybe_space();
            if (i == 5 && neg) send_item(CH_MINUS, 1'b0);
            send_number(v[i]);
            maybe_space();
            if (i < 5) send_item(CH_SEMI, 1'b0);
        end
        if ($urandom_range(0, 19) == 0) begin
            repeat ($urandom_range(1, 12)) begin
                send_item(CH_SEMI, 1'b0);
                send_number($urandom_range(0, 200));
            end
        end
        end_line(10);
    endtask

    task automatic send_broken_line();
        repeat ($urandom_range(0, 17)) begin
            case ($urandom_range(0, 5))
                0: send_item(CH_MINUS, 1'b0);
                1: begin
                    send_number($urandom_range(0, 99999));
                    send_item(CH_MINUS, 1'b0);
                end
                2: ;
                default: send_number($urandom_range(0, 3100));
            endcase
            send_item(CH_SEMI, 1'b0);
        end
        if ($urandom_range(0, 1)) send_number($urandom_range(0, 99999));
        end_line(25);
    endtask

    task automatic send_noise_line();
        repeat ($urandom_range(1, 12)) send_item(8'($urandom_range(0, 255)), 1'b0);
        end_line(30);
    endtask

    task automatic send_random_line();
        int k;
        k = $urandom_range(0, 99);
        if (k < 70) send_record_line();
        else if (k < 85) send_broken_line();
        else send_noise_line();
        lines++;
    endtask

    task automatic drain();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        wait (pending == 0);
        repeat (4) @(posedge aclk);
        burst_left = 0;
    endtask

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] a, input logic [11:0] d);
        @(negedge aclk);
        cfg_we <= 1'b1;
        cfg_addr <= a;
        cfg_wdata <= d;
        @(negedge aclk);
        cfg_we <= 1'b0;
        if (a == REG_YEAR_MIN) cur_lo = d;
        else cur_hi = d;
    endtask

    task automatic set_years(input logic [11:0] lo, input logic [11:0] hi);
        drain();
        write_reg(REG_YEAR_MIN, lo);
        write_reg(REG_YEAR_MAX, hi);
        repeat (2) @(posedge aclk);
        settings++;
    endtask

    initial begin
        int target;
        logic [11:0] same_year;
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        repeat (2) @(posedge aclk);

        // directed lines, sender without gaps
        burst_left = 1000;
        send_text("2024;12;31;24;60;-99\n");
        send_text("9-;;");
        send_item(8'hFF, 1'b0);
        send_item(CH_LF, 1'b0);
        send_eof();
        send_eof();
        drain();

        same_year = 12'($urandom_range(0, 4095));
        for (int p = 0; p < 6; p++) begin
            case (p)
                1: set_years(12'd0, 12'd4095);
                2: set_years(12'd4095, 12'd0);
                3: set_years(12'($urandom_range(0, 4095)), 12'($urandom_range(0, 4095)));
                4: set_years(YEAR_MIN_RST, YEAR_MAX_RST);
                5: set_years(same_year, same_year);
                default: ;
            endcase
            target = sent + PHASE_CHARS;
            while (sent < target) begin
                if (lines % 37 == 12) hold_req++;
                if (lines % 29 == 20) drain();
                send_random_line();
            end
        end

        @(negedge aclk);
        s_tvalid <= 1'b0;
        wait (pending == 0);
        repeat (10) @(posedge aclk);

        $display("sent %0d characters in %0d lines across %0d year-limit settings",
                 sent, lines, settings);
        $display("%0d records compared, %0d long receiver hold-offs", checked, hold_req);
        if (mismatches == 0 && pending == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("%0d mismatches, %0d records missing", mismatches, pending);
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
